### rtl/core/postfix_expression_evaluator_assert.svh
// Assertion macros for the postfix expression evaluator checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PFX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define PFX_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/core/pfx_pkg.sv
// Shared types and constants of the postfix expression evaluator.
// Used by the front end, the queue, the back end, the top level and the checker.
`timescale 1ns / 1ps

package pfx_pkg;

  // Operand width and stack size.
  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Depth of the queue between front and back; a power of two, at least 2.
  localparam int QUEUE_DEPTH = 2;

  // Character codes.
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Kind of a classified character.
  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } op_kind_e;

  // Error codes reported with a result.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_DIVZERO   = 3'd3,
    ERR_INVALID   = 3'd4
  } err_e;

  // One classified character as it travels from front to back.
  typedef struct packed {
    op_kind_e   kind;
    logic [3:0] digit;
    logic       last;
  } op_t;

endpackage

### rtl/core/pfx_front.sv
// Front end: accepts characters and classifies them into operations.
// Depends on pfx_pkg for the character codes and the op_t type.
`timescale 1ns / 1ps

module pfx_front import pfx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       op_valid_o,
  input  logic       op_ready_i,
  output op_t        op_o
);

  logic       valid_q;
  op_t        op_q;
  op_t        op_d;
  logic [7:0] offset;

  // Classify the incoming character.
  always_comb begin
    offset      = symbol_i - CHAR_0;
    op_d.digit  = offset[3:0];
    op_d.last   = last_i;
    priority if (symbol_i >= CHAR_0 && symbol_i <= CHAR_9) begin
      op_d.kind = OP_DIGIT;
    end else if (symbol_i == CHAR_PLUS) begin
      op_d.kind = OP_ADD;
    end else if (symbol_i == CHAR_MINUS) begin
      op_d.kind = OP_SUB;
    end else if (symbol_i == CHAR_STAR) begin
      op_d.kind = OP_MUL;
    end else if (symbol_i == CHAR_SLASH) begin
      op_d.kind = OP_DIV;
    end else begin
      op_d.kind = OP_BAD;
    end
  end

  // A new transfer is taken whenever the holding register is free or drains now.
  assign in_ready_o = !valid_q || op_ready_i;

  // Holding register toward the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      op_q    <= '0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
      op_q    <= op_d;
    end else if (op_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

### rtl/core/pfx_fifo.sv
// Short queue of classified operations between front and back end.
// Depends on pfx_pkg for op_t and QUEUE_DEPTH.
`timescale 1ns / 1ps

module pfx_fifo import pfx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_op_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  op_t               slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_op_o     = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers wrap on their own since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

### rtl/core/pfx_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfx_pkg for DATA_W.
`timescale 1ns / 1ps

module pfx_divider import pfx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DATA_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] steps_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] den_q;
  logic              neg_q;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      den_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      // Done pulses for one cycle right after the final step.
      done_q <= busy_q && (steps_q == STEP_W'(1));
      if (start_i && !busy_q) begin
        // Work on magnitudes; the sign is applied at the end.
        busy_q  <= 1'b1;
        steps_q <= STEP_W'(DATA_W);
        rem_q   <= '0;
        quo_q   <= dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
        den_q   <= divisor_i[DATA_W-1] ? (DATA_W'(0) - divisor_i) : divisor_i;
        neg_q   <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      end else if (busy_q) begin
        if (!diff[DATA_W]) begin
          rem_q <= diff[DATA_W-1:0];
        end else begin
          rem_q <= shifted[DATA_W-1:0];
        end
        quo_q   <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
        steps_q <= steps_q - STEP_W'(1);
        if (steps_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

### rtl/core/pfx_back.sv
// Back end: operand stack, arithmetic and result register.
// Depends on pfx_pkg and instantiates pfx_divider.
`timescale 1ns / 1ps

module pfx_back import pfx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     op_valid_i,
  output logic                     op_ready_o,
  input  op_t                      op_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [2:0]               out_error_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q;
  op_t               op_q;
  logic [DATA_W-1:0] tos_q;
  logic [CNT_W-1:0]  cnt_q;
  err_e              err_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  err_e              out_error_q;

  // Stack entries below the top; the top itself lives in tos_q.
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  logic              take;
  logic              full;
  logic              push_wr;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] alu_res;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;

  assign op_ready_o = (state_q == ST_IDLE);
  assign take       = op_valid_i && op_ready_o;
  assign full       = (cnt_q == CNT_W'(STACK_DEPTH));
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign cnt_m2     = cnt_q - CNT_W'(2);
  assign wr_idx     = cnt_m1[IDX_W-1:0];
  assign rd_idx     = cnt_m2[IDX_W-1:0];

  // A digit spills the old top into memory unless the stack was empty.
  assign push_wr = take && (err_q == ERR_NONE) && (op_i.kind == OP_DIGIT) &&
                   !full && (cnt_q != '0);

  // Stack memory: one write port, one registered read port at the left operand.
  always_ff @(posedge clk_i) begin
    if (push_wr) begin
      stack_mem[wr_idx] <= tos_q;
    end
    rd_data_q <= stack_mem[rd_idx];
  end

  // Add, subtract and multiply; the left operand comes from memory.
  always_comb begin
    unique case (op_q.kind)
      OP_ADD:  alu_res = rd_data_q + tos_q;
      OP_SUB:  alu_res = rd_data_q - tos_q;
      OP_MUL:  alu_res = rd_data_q * tos_q;
      default: alu_res = rd_data_q + tos_q;
    endcase
  end

  assign div_start = (state_q == ST_EXEC) && (op_q.kind == OP_DIV);

  pfx_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_data_q),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer with the stack pointer, error flag and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      tos_q       <= '0;
      cnt_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_error_q <= ERR_NONE;
    end else begin
      // A transferred result is dropped unless a new one is loaded in its place.
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            op_q <= op_i;
            if (err_q != ERR_NONE) begin
              // After an error the rest of the expression is skipped.
              state_q <= op_i.last ? ST_EMIT : ST_IDLE;
            end else begin
              unique case (op_i.kind)
                OP_DIGIT: begin
                  if (full) begin
                    err_q <= ERR_OVERFLOW;
                  end else begin
                    tos_q <= DATA_W'(op_i.digit);
                    cnt_q <= cnt_q + CNT_W'(1);
                  end
                  state_q <= op_i.last ? ST_EMIT : ST_IDLE;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (cnt_q < CNT_W'(2)) begin
                    err_q   <= ERR_UNDERFLOW;
                    state_q <= op_i.last ? ST_EMIT : ST_IDLE;
                  end else if (op_i.kind == OP_DIV && tos_q == '0) begin
                    err_q   <= ERR_DIVZERO;
                    state_q <= op_i.last ? ST_EMIT : ST_IDLE;
                  end else begin
                    state_q <= ST_EXEC;
                  end
                end
                default: begin
                  err_q   <= ERR_INVALID;
                  state_q <= op_i.last ? ST_EMIT : ST_IDLE;
                end
              endcase
            end
          end
        end
        ST_EXEC: begin
          if (op_q.kind == OP_DIV) begin
            state_q <= ST_DIV;
          end else begin
            tos_q   <= alu_res;
            cnt_q   <= cnt_m1;
            state_q <= op_q.last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            tos_q   <= div_quot;
            cnt_q   <= cnt_m1;
            state_q <= op_q.last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          // Hand the result over once the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_value_q <= (cnt_q != '0) ? tos_q : '0;
            if (err_q != ERR_NONE) begin
              out_error_q <= err_q;
            end else if (cnt_q == '0) begin
              out_error_q <= ERR_UNDERFLOW;
            end else begin
              out_error_q <= ERR_NONE;
            end
            cnt_q   <= '0;
            err_q   <= ERR_NONE;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_error_o = out_error_q;

endmodule

### rtl/core/postfix_expression_evaluator.sv
// Postfix (reverse Polish) expression evaluator: one ASCII character per
// input transfer, the final character flagged by tlast. Digits push their
// value, + - * / combine the two top entries with 32-bit wrapping, and
// division truncates toward zero. After the final character one output
// transfer carries the top of the stack (0 if empty) and an error code
// (0 ok, 1 underflow, 2 overflow, 3 divide by zero, 4 invalid character);
// only the first error of an expression is reported, later characters are
// skipped, and the stack is cleared for the next expression. The front end
// accepts one character per cycle into a two-entry queue while it has room;
// the back end takes the next character only once it is idle again: + - *
// do one registered stack-memory read, then the ALU; / does the read,
// divider start, 32 bit-serial steps and write-back; and the final
// character also loads the output register. Stack depth is 32 entries;
// no clearing pass is needed.
// Depends on pfx_pkg, pfx_front, pfx_fifo, pfx_back and pfx_divider.
`timescale 1ns / 1ps

module postfix_expression_evaluator import pfx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] symbol
  input  logic                     s_axis_tlast,   // last
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic signed [DATA_W-1:0] m_axis_tdata,   // [31:0] value
  output logic [2:0]               m_axis_tuser    // [2:0] error
);

  logic front_valid;
  logic front_ready;
  op_t  front_op;
  logic queue_valid;
  logic queue_ready;
  op_t  queue_op;

  pfx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .symbol_i   (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .op_valid_o (front_valid),
    .op_ready_i (front_ready),
    .op_o       (front_op)
  );

  pfx_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_op_i    (front_op),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_op_o     (queue_op)
  );

  pfx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (queue_valid),
    .op_ready_o  (queue_ready),
    .op_i        (queue_op),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_error_o (m_axis_tuser)
  );

endmodule

### rtl/core/pfx_checker.sv
// Port-level checker for the postfix expression evaluator, bound to the top.
// Depends on pfx_pkg and the postfix_expression_evaluator_assert.svh macros.
`timescale 1ns / 1ps
`include "postfix_expression_evaluator_assert.svh"

module pfx_checker import pfx_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     s_axis_tlast,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic signed [DATA_W-1:0] m_axis_tdata,
  input logic [2:0]               m_axis_tuser
);

  // Front register, queue, back end and output register bound the backlog.
  localparam int PEND_MAX = QUEUE_DEPTH + 3;
  localparam int PEND_W   = $clog2(PEND_MAX + 1) + 1;

  logic [PEND_W-1:0] pending_q;
  logic [PEND_W-1:0] pending_d;
  logic              last_in;
  logic              result_out;
  logic              out_stall;
  logic [DATA_W+2:0] out_word;

  assign last_in    = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign result_out = m_axis_tvalid && m_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_word   = {m_axis_tdata, m_axis_tuser};

  // Expressions closed at the input whose result has not yet been transferred.
  always_comb begin
    pending_d = pending_q;
    if (last_in && !result_out) begin
      pending_d = pending_q + PEND_W'(1);
    end else if (result_out && !last_in) begin
      pending_d = pending_q - PEND_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `PFX_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled result changed")
  `PFX_NEVER(a_err_range, m_axis_tvalid && (m_axis_tuser > ERR_INVALID), "error code out of range")
  `PFX_NEVER(a_no_orphan, m_axis_tvalid && (pending_q == '0), "result without a closed expression")
  `PFX_NEVER(a_backlog, pending_q > PEND_W'(PEND_MAX), "backlog above pipeline capacity")

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (.*);

### dv/postfix_expression_evaluator_tb.sv
// Self-checking testbench for the postfix expression evaluator: a queue-fed stream driver,
// a stream monitor with a built-in stack predictor, and random sender and receiver idling.
// Depends on pfx_pkg and the postfix_expression_evaluator RTL.
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;
  import pfx_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_CHARS = 1400;
  localparam int MAX_REPORTS  = 10;

  // One character as queued for the driver; drain holds it back until all results are in.
  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       drain;
  } char_item_t;

  // One expected output transfer.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    err_e              error;
  } expr_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata;   // [7:0] symbol
  logic                     s_axis_tlast;   // last
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic signed [DATA_W-1:0] m_axis_tdata;   // [31:0] value
  logic [2:0]               m_axis_tuser;   // [2:0] error

  char_item_t   char_q[$];
  expr_result_t expr_results_q[$];

  // Predictor state: operand stack, entry count and first error of the open expression.
  logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
  int                eval_depth;
  err_e              eval_err;

  logic sym_taken;
  int   cycle_count;
  int   mismatches;
  int   chars_taken;
  int   exprs_done;
  int   err_hist [5];
  int   gap_left;
  int   burst_left;
  int   rx_left;
  int   rx_mode;
  bit   drain_next;

  postfix_expression_evaluator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Only the first error of an expression is kept.
  function automatic void flag_error(err_e code);
    if (eval_err == ERR_NONE) begin
      eval_err = code;
    end
  endfunction

  // Apply one accepted character to the predicted stack; a final character queues a result.
  task automatic rpn_apply(input logic [7:0] sym, input logic is_last);
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] mag_l;
    logic [DATA_W-1:0] mag_r;
    logic [DATA_W-1:0] quo;
    expr_result_t      outcome;
    bit                ok;
    ok = 1'b1;
    res = '0;
    if (eval_err == ERR_NONE) begin
      if (sym >= CHAR_0 && sym <= CHAR_9) begin
        if (eval_depth >= STACK_DEPTH) begin
          flag_error(ERR_OVERFLOW);
        end else begin
          eval_stack[eval_depth] = DATA_W'(sym - CHAR_0);
          eval_depth++;
        end
      end else if (sym == CHAR_PLUS || sym == CHAR_MINUS || sym == CHAR_STAR ||
                   sym == CHAR_SLASH) begin
        if (eval_depth < 2) begin
          flag_error(ERR_UNDERFLOW);
        end else begin
          rhs = eval_stack[eval_depth-1];
          lhs = eval_stack[eval_depth-2];
          if (sym == CHAR_PLUS) begin
            res = lhs + rhs;
          end else if (sym == CHAR_MINUS) begin
            res = lhs - rhs;
          end else if (sym == CHAR_STAR) begin
            res = lhs * rhs;
          end else if (rhs == '0) begin
            // Both operands stay on the stack.
            flag_error(ERR_DIVZERO);
            ok = 1'b0;
          end else begin
            // Divide magnitudes, then fix the sign: truncation toward zero.
            mag_l = lhs[DATA_W-1] ? -lhs : lhs;
            mag_r = rhs[DATA_W-1] ? -rhs : rhs;
            quo   = mag_l / mag_r;
            res   = (lhs[DATA_W-1] != rhs[DATA_W-1]) ? -quo : quo;
          end
          if (ok) begin
            eval_stack[eval_depth-2] = res;
            eval_depth--;
          end
        end
      end else begin
        flag_error(ERR_INVALID);
      end
    end
    if (is_last) begin
      if (eval_depth > 0) begin
        outcome.value = eval_stack[eval_depth-1];
      end else begin
        outcome.value = '0;
        flag_error(ERR_UNDERFLOW);
      end
      outcome.error = eval_err;
      expr_results_q.push_back(outcome);
      err_hist[eval_err]++;
      exprs_done++;
      eval_depth = 0;
      eval_err   = ERR_NONE;
    end
  endtask

  // Queue one character; the first one after a drain request carries the drain mark.
  function automatic void push_char(logic [7:0] sym, logic is_last);
    char_item_t item;
    item.sym   = sym;
    item.last  = is_last;
    item.drain = drain_next;
    drain_next = 1'b0;
    char_q.push_back(item);
  endfunction

  function automatic void push_text(string txt);
    for (int i = 0; i < txt.len(); i++) begin
      push_char(txt[i], i == txt.len() - 1);
    end
  endfunction

  function automatic logic [7:0] pick_op(bit mul_heavy);
    logic [7:0] op;
    if (mul_heavy && $urandom_range(0, 1) == 1) begin
      op = CHAR_STAR;
    end else begin
      case ($urandom_range(0, 3))
        0: op = CHAR_PLUS;
        1: op = CHAR_MINUS;
        2: op = CHAR_STAR;
        default: op = CHAR_SLASH;
      endcase
    end
    return op;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CHAR_0 + 8'($urandom_range(0, 9));
  endfunction

  // Random well-formed expression: digits and operators interleaved, never underflowing.
  function automatic void add_valid_expr(int n_dig, bit mul_heavy);
    int depth;
    int left;
    depth = 0;
    left  = n_dig;
    while (left > 0 || depth > 1) begin
      if (depth < 2 || (left > 0 && $urandom_range(0, 1) == 1)) begin
        depth++;
        left--;
        push_char(pick_digit(), left == 0 && depth == 1);
      end else begin
        depth--;
        push_char(pick_op(mul_heavy), left == 0 && depth == 1);
      end
    end
  endfunction

  // Push n digits, then n-1 operators; 32 fills the stack, 33 overflows it.
  function automatic void add_deep_expr(int n_dig);
    for (int i = 0; i < n_dig; i++) begin
      push_char(pick_digit(), 1'b0);
    end
    for (int i = 1; i < n_dig; i++) begin
      push_char(pick_op(1'b0), i == n_dig - 1);
    end
  endfunction

  // Build 2^31, which wraps to the most negative value, then divide it by minus one.
  function automatic void add_min_div_expr();
    push_char(CHAR_0 + 8'd2, 1'b0);
    for (int i = 0; i < 30; i++) begin
      push_char(CHAR_0 + 8'd2, 1'b0);
      push_char(CHAR_STAR, 1'b0);
    end
    push_text("01-/");
  endfunction

  // Mismatch check of one output transfer against the oldest expectation.
  task automatic check_result(input logic [DATA_W-1:0] got_val, input logic [2:0] got_err);
    expr_result_t exp_res;
    if (expr_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("unexpected result: value %0d error %0d", $signed(got_val), got_err);
      end
    end else begin
      exp_res = expr_results_q.pop_front();
      if (got_val !== exp_res.value || got_err !== exp_res.error) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch in expression %0d: value exp %0d got %0d, error exp %0d got %0d",
                   exprs_done - expr_results_q.size(), $signed(exp_res.value),
                   $signed(got_val), exp_res.error, got_err);
        end
      end
    end
  endtask

  // Input driver: bursts of transfers with random gaps, fed from the character queue.
  always @(negedge clk_i) begin : sym_driver
    char_item_t cur;
    if (rst_ni) begin
      if (!s_axis_tvalid || sym_taken) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (char_q.size() != 0 &&
                     !(char_q[0].drain && expr_results_q.size() != 0)) begin
          cur = char_q.pop_front();
          s_axis_tdata  <= cur.sym;
          s_axis_tlast  <= cur.last;
          s_axis_tvalid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready: changes between always-ready, random, mostly stalled and periodic modes.
  always @(negedge clk_i) begin : result_ready_driver
    logic rdy;
    if (rst_ni) begin
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 5) == 0);
        default: rdy = (cycle_count % 7) < 3;
      endcase
      m_axis_tready <= rdy;
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(10, 80);
      end else begin
        rx_left--;
      end
    end
  end

  // Monitor: predicts on every accepted character and checks every output transfer.
  always @(posedge clk_i) begin : rpn_monitor
    if (rst_ni) begin
      cycle_count++;
      sym_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        chars_taken++;
        rpn_apply(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata, m_axis_tuser);
      end
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int gen_chars;
    int kind;
    int mark;
    int idx;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    sym_taken     = 1'b0;
    rst_ni        = 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    chars_taken   = 0;
    exprs_done    = 0;
    eval_depth    = 0;
    eval_err      = ERR_NONE;
    gap_left      = 0;
    burst_left    = 0;
    rx_left       = 0;
    rx_mode       = 0;
    drain_next    = 1'b0;
    foreach (err_hist[i]) err_hist[i] = 0;

    // Directed part: extreme digits, each operator, negative quotient, divide by zero,
    // operator underflow and invalid characters at both ends of the byte range.
    push_text("9");
    push_text("34+");
    push_text("95-");
    push_text("78*");
    push_text("93/");
    push_text("09-4/");
    push_text("50/");
    push_text("+");
    push_char(8'hFF, 1'b1);
    push_char(8'h00, 1'b0);
    push_text("7");

    // Random part: mostly well-formed expressions, some deep, some broken, some noise.
    gen_chars = 0;
    mark = 0;
    drain_next = 1'b1;
    while (gen_chars < RANDOM_CHARS) begin
      if (gen_chars - mark > 250) begin
        drain_next = 1'b1;
        mark = gen_chars;
      end
      idx  = char_q.size();
      kind = $urandom_range(0, 99);
      if (kind < 58) begin
        add_valid_expr($urandom_range(1, 6), 1'b0);
      end else if (kind < 68) begin
        add_valid_expr($urandom_range(7, 16), 1'b1);
      end else if (kind < 72) begin
        add_deep_expr($urandom_range(32, 33));
      end else if (kind < 75) begin
        add_min_div_expr();
      end else if (kind < 87) begin
        // Well-formed expression with one character replaced.
        add_valid_expr($urandom_range(2, 8), 1'b0);
        mark = mark;
        char_q[$urandom_range(idx, char_q.size() - 1)].sym =
          ($urandom_range(0, 1) == 1) ? pick_op(1'b0) : 8'($urandom_range(0, 255));
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          push_char(8'($urandom_range(0, 255)), i == 1);
        end
      end
      gen_chars += char_q.size() - idx;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_q.size() != 0 || s_axis_tvalid || expr_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);

    $display("covered %0d expressions from %0d characters in %0d cycles", exprs_done,
             chars_taken, cycle_count);
    $display("error codes seen: none %0d, underflow %0d, overflow %0d, div0 %0d, invalid %0d",
             err_hist[0], err_hist[1], err_hist[2], err_hist[3], err_hist[4]);
    if (mismatches == 0 && expr_results_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/pfx_pkg.sv
rtl/core/pfx_front.sv
rtl/core/pfx_fifo.sv
rtl/core/pfx_divider.sv
rtl/core/pfx_back.sv
rtl/core/postfix_expression_evaluator.sv
rtl/core/pfx_checker.sv
dv/postfix_expression_evaluator_tb.sv
